// File: design/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg: shared types and constants for the sorted index set engine
// Holds the key store geometry, function and status codes, and the word
// layouts on both channels and on the internal queue.
// ----------------------------------------------------------------------------
package sis_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_W    = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int FUNC_W   = 3;
    localparam int STAT_W   = 2;
    localparam int NREG     = 2;
    localparam int CFGI_W   = $clog2(NREG);

    localparam logic [KEY_W-1:0] NONE_VALUE  = {KEY_W{1'b1}};
    localparam logic [KEY_W-1:0] RANGE_HI_RST = {{(KEY_W-1){1'b1}}, 1'b0};

    // function codes
    localparam logic [FUNC_W-1:0] FN_ADD   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_REM   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_CON   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_NG    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_NL    = 3'd4;
    localparam logic [FUNC_W-1:0] FN_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FN_LAST  = 3'd6;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // configuration register indexes
    localparam logic [CFGI_W-1:0] REG_RANGE_LOW  = 1'b0;
    localparam logic [CFGI_W-1:0] REG_RANGE_HIGH = 1'b1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [KEY_W-1:0]  value;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  entry_count;
    } rsp_t;

    // queue word between front and back
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic              in_range;
    } cmd_t;

endpackage

// File: design/sis_ram.sv
// ----------------------------------------------------------------------------
// sis_ram: generic single write, single read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/sis_front.sv
// ----------------------------------------------------------------------------
// sis_front: request intake and range classification
// Holds the range registers, tags each request word with its range check
// and buffers it in a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module sis_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [sis_pkg::CFGI_W-1:0] cfg_index,
    input  logic [sis_pkg::KEY_W-1:0]  cfg_data,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  sis_pkg::req_t              req_word,
    output logic                       cmd_valid,
    input  logic                       cmd_ready,
    output sis_pkg::cmd_t              cmd_word
);
    import sis_pkg::*;

    logic [KEY_W-1:0] lo_reg, hi_reg;
    logic [KEY_W-1:0] eff_hi;
    logic             in_range;
    cmd_t             q_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;
    logic             push, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg <= '0;
            hi_reg <= RANGE_HI_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RANGE_LOW:  lo_reg <= cfg_data;
                REG_RANGE_HIGH: hi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // normalize the upper bound
    always_comb
    begin
        if (hi_reg > lo_reg)
        begin
            eff_hi = (hi_reg == NONE_VALUE) ? hi_reg - KEY_W'(1) : hi_reg;
        end
        else
        begin
            eff_hi = lo_reg;
        end
    end

    assign in_range  = (req_word.key >= lo_reg) && (req_word.key <= eff_hi);
    assign req_ready = (cnt_reg != 2'd2);
    assign push      = req_valid && req_ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd_word  = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= '{func: req_word.func, key: req_word.key, in_range: in_range};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of bounds");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) |-> (wp_reg != rp_reg)) else $error("queue pointers disagree");
    a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 || cnt_reg == 2'd0) |-> (wp_reg == rp_reg))
        else $error("queue pointers disagree with count");

endmodule

// File: design/sis_back.sv
// ----------------------------------------------------------------------------
// sis_back: key store sequencer
// Scans the sorted store one entry per cycle, shifts entries for insert and
// delete, keeps the cursor and count, and registers the response word.
// ----------------------------------------------------------------------------
module sis_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  sis_pkg::cmd_t cmd_word,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output sis_pkg::rsp_t rsp_word
);
    import sis_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_SHUP = 6'b000100,
        S_SHDN = 6'b001000,
        S_RDW  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    localparam logic [CNT_W-1:0] CAP  = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    state_t              state_reg, state_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   cpos_reg, cpos_next;
    logic                cval_reg, cval_next;
    logic [KEY_W-1:0]    clast_reg, clast_next;
    logic [CNT_W-1:0]    ra_reg, ra_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    da_reg, da_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic                pend_reg, pend_next;
    logic                down_reg, down_next;
    logic                rfound_reg, rfound_next;
    logic [KEY_W-1:0]    rval_reg, rval_next;
    logic [STAT_W-1:0]   rstat_reg, rstat_next;
    rsp_t                out_reg;
    logic                out_valid_reg;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [KEY_W-1:0]    ram_wdata, rdata;
    logic                match, hit, eq, slot_free;
    logic [CNT_W-1:0]    cpos_w;

    sis_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    assign cpos_w    = {{(CNT_W-ADDR_W){1'b0}}, cpos_reg};
    assign eq        = (rdata == key_reg);
    assign slot_free = !out_valid_reg || rsp_ready;
    assign cmd_ready = (state_reg == S_IDLE);

    always_comb
    begin
        case (func_reg)
            FN_NG:   match = rdata > key_reg;
            FN_NL:   match = rdata < key_reg;
            default: match = rdata >= key_reg;
        endcase
    end
    assign hit = pend_reg && match;

    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        key_next    = key_reg;
        count_next  = count_reg;
        cpos_next   = cpos_reg;
        cval_next   = cval_reg;
        clast_next  = clast_reg;
        ra_next     = ra_reg;
        rem_next    = rem_reg;
        da_next     = da_reg;
        pos_next    = pos_reg;
        pend_next   = pend_reg;
        down_next   = down_reg;
        rfound_next = rfound_reg;
        rval_next   = rval_reg;
        rstat_next  = rstat_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = rdata;
        ram_raddr   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    func_next   = cmd_word.func;
                    key_next    = cmd_word.key;
                    rfound_next = 1'b0;
                    rval_next   = NONE_VALUE;
                    rstat_next  = ST_OK;
                    pend_next   = 1'b0;
                    down_next   = 1'b0;
                    ra_next     = '0;
                    rem_next    = count_reg;
                    state_next  = S_DONE;
                    case (cmd_word.func)
                        FN_ADD, FN_REM, FN_CON:
                        begin
                            if (!cmd_word.in_range)
                            begin
                                rstat_next = ST_RANGE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        FN_NG:
                        begin
                            if (cval_reg && clast_reg == cmd_word.key)
                            begin
                                if (cpos_w + ONE < count_reg)
                                begin
                                    da_next    = cpos_w + ONE;
                                    ram_raddr  = ADDR_W'(cpos_w + ONE);
                                    state_next = S_RDW;
                                end
                                else
                                begin
                                    cval_next = 1'b0;
                                end
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        FN_NL:
                        begin
                            if (cval_reg && clast_reg == cmd_word.key)
                            begin
                                if (cpos_reg != '0 && cpos_w - ONE < count_reg)
                                begin
                                    da_next    = cpos_w - ONE;
                                    ram_raddr  = cpos_reg - ADDR_W'(1);
                                    state_next = S_RDW;
                                end
                                else
                                begin
                                    cval_next = 1'b0;
                                end
                            end
                            else
                            begin
                                down_next  = 1'b1;
                                ra_next    = count_reg - ONE;
                                state_next = S_SCAN;
                            end
                        end
                        FN_FIRST:
                        begin
                            if (count_reg != '0)
                            begin
                                da_next    = '0;
                                state_next = S_RDW;
                            end
                        end
                        FN_LAST:
                        begin
                            if (count_reg != '0)
                            begin
                                da_next    = count_reg - ONE;
                                ram_raddr  = ADDR_W'(count_reg - ONE);
                                state_next = S_RDW;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_RDW:
            begin
                cpos_next   = ADDR_W'(da_reg);
                cval_next   = 1'b1;
                clast_next  = rdata;
                rfound_next = 1'b1;
                rval_next   = rdata;
                state_next  = S_DONE;
            end

            S_SCAN:
            begin
                if (hit || (rem_reg == '0 && !pend_reg))
                begin
                    state_next = S_DONE;
                    case (func_reg)
                        FN_ADD:
                        begin
                            if (hit && eq)
                            begin
                                rfound_next = 1'b1;
                            end
                            else if (count_reg == CAP)
                            begin
                                rstat_next = ST_FULL;
                            end
                            else
                            begin
                                pos_next   = hit ? da_reg : count_reg;
                                ra_next    = count_reg - ONE;
                                rem_next   = count_reg - (hit ? da_reg : count_reg);
                                pend_next  = 1'b0;
                                state_next = S_SHUP;
                            end
                        end
                        FN_REM:
                        begin
                            if (count_reg != '0)
                            begin
                                cval_next = 1'b0;
                            end
                            if (hit && eq)
                            begin
                                rfound_next = 1'b1;
                                ra_next     = da_reg + ONE;
                                rem_next    = count_reg - ONE - da_reg;
                                pend_next   = 1'b0;
                                state_next  = S_SHDN;
                            end
                        end
                        FN_CON:
                        begin
                            rfound_next = hit && eq;
                        end
                        default:
                        begin
                            if (hit)
                            begin
                                cpos_next   = ADDR_W'(da_reg);
                                cval_next   = 1'b1;
                                clast_next  = rdata;
                                rfound_next = 1'b1;
                                rval_next   = rdata;
                            end
                        end
                    endcase
                end
                else if (rem_reg != '0)
                begin
                    ram_raddr = ADDR_W'(ra_reg);
                    da_next   = ra_reg;
                    ra_next   = down_reg ? ra_reg - ONE : ra_reg + ONE;
                    rem_next  = rem_reg - ONE;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            S_SHUP:
            begin
                // move entries up one slot, top first
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(da_reg + ONE);
                end
                if (rem_reg != '0)
                begin
                    ram_raddr = ADDR_W'(ra_reg);
                    da_next   = ra_reg;
                    ra_next   = ra_reg - ONE;
                    rem_next  = rem_reg - ONE;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = ADDR_W'(pos_reg);
                        ram_wdata   = key_reg;
                        count_next  = count_reg + ONE;
                        cval_next   = 1'b0;
                        rfound_next = 1'b1;
                        state_next  = S_DONE;
                    end
                end
            end

            S_SHDN:
            begin
                // close the gap, bottom first
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(da_reg - ONE);
                end
                if (rem_reg != '0)
                begin
                    ram_raddr = ADDR_W'(ra_reg);
                    da_next   = ra_reg;
                    ra_next   = ra_reg + ONE;
                    rem_next  = rem_reg - ONE;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - ONE;
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        key_reg    <= key_next;
        ra_reg     <= ra_next;
        rem_reg    <= rem_next;
        da_reg     <= da_next;
        pos_reg    <= pos_next;
        down_reg   <= down_next;
        rfound_reg <= rfound_next;
        rval_reg   <= rval_next;
        rstat_reg  <= rstat_next;
        if (state_reg == S_DONE && slot_free)
        begin
            out_reg <= '{found: rfound_reg, value: rval_reg, status: rstat_reg,
                         entry_count: count_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cpos_reg      <= '0;
            cval_reg      <= 1'b1;
            clast_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cpos_reg  <= cpos_next;
            cval_reg  <= cval_next;
            clast_reg <= clast_next;
            pend_reg  <= pend_next;
            if (state_reg == S_DONE && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP) else $error("entry count above capacity");
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && state_reg == S_IDLE)) else $error("store written while idle");
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response without completion");
    a_count_by_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(state_reg == S_SHUP || state_reg == S_SHDN))
        else $error("count changed outside a shift");

endmodule

// File: design/sorted_index_set_engine_top.sv
// ----------------------------------------------------------------------------
// sorted_index_set_engine_top: sorted key set with successor cursor
// Keeps up to CAPACITY distinct keys in ascending order in one RAM and
// answers add, remove, contains, next-greater, next-less, first and last.
// ----------------------------------------------------------------------------
//  channel   handshake             word
//  --------  --------------------  ---------------------------------------
//  request   req_valid/req_ready   req_word  {func, key}
//  response  rsp_valid/rsp_ready   rsp_word  {found, value, status, count}
//  config    cfg_we                cfg_index, cfg_data (no wait)
//
//  One word at a time in the back end. A scan reads one store entry
//  per cycle and stops at the insert or delete point; the shift then
//  moves one entry per cycle over the rest of the store. Cursor steps,
//  first and last take one RAM read. The single read port of the store
//  RAM sets this pace.
//  Reset: asynchronous, clears count and cursor; store contents need none.
//  Stalls: a two-word queue lets requests land while the back end works;
//  a held response blocks only the next completion.
// ----------------------------------------------------------------------------
module sorted_index_set_engine_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [sis_pkg::CFGI_W-1:0] cfg_index,
    input  logic [sis_pkg::KEY_W-1:0]  cfg_data,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  sis_pkg::req_t              req_word,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output sis_pkg::rsp_t              rsp_word
);
    import sis_pkg::*;

    // front to back queue word
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd_word;

    // accept, range-check and buffer requests
    sis_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_word  (cmd_word)
    );

    // run the store sequencer and hold the response
    sis_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_word  (cmd_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

endmodule

// File: tb/sorted_index_set_engine_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_index_set_engine_top_tb: self-checking bench for the sorted key set
// Drives add, remove, contains, cursor and first/last requests with random
// bursts and response stalls, predicts every response word with a model of
// the set and its cursor, and compares field by field. Walks several range
// settings.
// ----------------------------------------------------------------------------
module sorted_index_set_engine_top_tb;

    import sis_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 8;

    // ------------------------------------------------------------------------
    // Predictor of the set: its own copy of store, count, cursor and range.
    // note() runs the request against the copy and queues the expected word;
    // check() pops the oldest expectation and compares it with the DUT word.
    // ------------------------------------------------------------------------
    class key_set_model;
        logic [KEY_W-1:0] keys [CAPACITY];
        int               held;
        int               cur_pos;
        bit               cur_ok;
        logic [KEY_W-1:0] cur_last;
        logic [KEY_W-1:0] lo;
        logic [KEY_W-1:0] hi;
        rsp_t             pending_rsp [$];

        function new();
            held     = 0;
            cur_pos  = 0;
            cur_ok   = 1'b1;
            cur_last = '0;
            lo       = '0;
            hi       = RANGE_HI_RST;
        endfunction

        function void write_reg(logic [CFGI_W-1:0] idx, logic [KEY_W-1:0] data);
            if (idx == REG_RANGE_LOW)
                lo = data;
            else
                hi = data;
        endfunction

        function logic [KEY_W-1:0] top_key();
            if (hi > lo)
                return (hi == NONE_VALUE) ? hi - 1 : hi;
            return lo;
        endfunction

        function bit accepts(logic [KEY_W-1:0] k);
            return (k >= lo) && (k <= top_key());
        endfunction

        function void point_at(int pos);
            cur_pos  = pos;
            cur_ok   = 1'b1;
            cur_last = keys[pos];
        endfunction

        function int pending();
            return pending_rsp.size();
        endfunction

        function void note(req_t rq);
            rsp_t e;
            int   i;
            int   j;
            e.found  = 1'b0;
            e.value  = NONE_VALUE;
            e.status = ST_OK;
            case (rq.func)
                FN_ADD:
                begin
                    if (!accepts(rq.key))
                        e.status = ST_RANGE;
                    else
                    begin
                        i = 0;
                        while (i < held && keys[i] < rq.key)
                            i++;
                        if (i < held && keys[i] == rq.key)
                            e.found = 1'b1;
                        else if (held >= CAPACITY)
                            e.status = ST_FULL;
                        else
                        begin
                            // open a slot at i
                            for (j = held; j > i; j--)
                                keys[j] = keys[j-1];
                            keys[i] = rq.key;
                            held++;
                            cur_ok  = 1'b0;
                            e.found = 1'b1;
                        end
                    end
                end
                FN_REM:
                begin
                    if (!accepts(rq.key))
                        e.status = ST_RANGE;
                    else if (held > 0)
                    begin
                        i = 0;
                        while (i < held && keys[i] != rq.key)
                            i++;
                        if (i < held)
                        begin
                            // close the gap at i
                            for (j = i; j < held - 1; j++)
                                keys[j] = keys[j+1];
                            held--;
                            e.found = 1'b1;
                        end
                        cur_ok = 1'b0;
                    end
                end
                FN_CON:
                begin
                    if (!accepts(rq.key))
                        e.status = ST_RANGE;
                    else
                        for (i = 0; i < held; i++)
                            if (keys[i] == rq.key)
                                e.found = 1'b1;
                end
                FN_NG:
                begin
                    if (cur_ok && cur_last == rq.key)
                    begin
                        if (cur_pos + 1 < held)
                        begin
                            point_at(cur_pos + 1);
                            e.found = 1'b1;
                            e.value = cur_last;
                        end
                        else
                            cur_ok = 1'b0;
                    end
                    else
                        for (i = 0; i < held; i++)
                            if (!e.found && keys[i] > rq.key)
                            begin
                                point_at(i);
                                e.found = 1'b1;
                                e.value = cur_last;
                            end
                end
                FN_NL:
                begin
                    if (cur_ok && cur_last == rq.key)
                    begin
                        if (cur_pos > 0 && cur_pos - 1 < held)
                        begin
                            point_at(cur_pos - 1);
                            e.found = 1'b1;
                            e.value = cur_last;
                        end
                        else
                            cur_ok = 1'b0;
                    end
                    else
                        for (i = held; i > 0; i--)
                            if (!e.found && keys[i-1] < rq.key)
                            begin
                                point_at(i - 1);
                                e.found = 1'b1;
                                e.value = cur_last;
                            end
                end
                FN_FIRST:
                begin
                    if (held > 0)
                    begin
                        point_at(0);
                        e.found = 1'b1;
                        e.value = cur_last;
                    end
                end
                FN_LAST:
                begin
                    if (held > 0)
                    begin
                        point_at(held - 1);
                        e.found = 1'b1;
                        e.value = cur_last;
                    end
                end
                default:
                begin
                end
            endcase
            e.entry_count = held[CNT_W-1:0];
            pending_rsp.push_back(e);
        endfunction

        function bit check(rsp_t got, output string msg);
            rsp_t e;
            msg = "";
            if (pending_rsp.size() == 0)
            begin
                msg = "response word with nothing outstanding";
                return 1'b0;
            end
            e = pending_rsp.pop_front();
            if (got.found !== e.found)
                msg = {msg, $sformatf(" found %0b/%0b", got.found, e.found)};
            if (got.value !== e.value)
                msg = {msg, $sformatf(" value %h/%h", got.value, e.value)};
            if (got.status !== e.status)
                msg = {msg, $sformatf(" status %0d/%0d", got.status, e.status)};
            if (got.entry_count !== e.entry_count)
                msg = {msg, $sformatf(" count %0d/%0d", got.entry_count,
                                      e.entry_count)};
            return (msg == "");
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFGI_W-1:0]    cfg_index = '0;
    logic [KEY_W-1:0]     cfg_data = '0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    req_t                 req_word = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    rsp_t                 rsp_word;

    key_set_model model = new();
    int errors = 0;
    int idle_cycles = 0;
    int burst_left = 0;

    sorted_index_set_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

    always #10 clk = ~clk;

    task report(input string m);
        errors++;
        $display("ERROR @%0t:%s", $realtime, m);
    endtask

    // ------------------------------------------------------------------------
    // Response side: check every word taken at a rising edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        string msg;
        if (rst_n && rsp_valid && rsp_ready)
            if (!model.check(rsp_word, msg))
                report(msg);
    end

    // ------------------------------------------------------------------------
    // Receiver stall pattern: periodically pick a mode at random among always
    // ready, coin flip, one-in-four, and long stall stretches.
    // ------------------------------------------------------------------------
    int stall_mode = 0;
    int mode_age = 0;
    int stall_left = 0;

    always @(negedge clk)
    begin
        mode_age++;
        if (mode_age >= 100)
        begin
            mode_age   = 0;
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    rsp_ready <= 1'b0;
                end
                else
                begin
                    stall_left = $urandom_range(0, 15);
                    rsp_ready <= 1'b1;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles in which neither channel moves a word.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Issue one request word. Insert a random gap when a burst runs out;
    // otherwise keep valid high straight into the next word.
    task send(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        req_valid     <= 1'b1;
        req_word.func <= f;
        req_word.key  <= k;
        do
            @(posedge clk);
        while (!req_ready);
        model.note(req_word);
        burst_left--;
    endtask

    // Drop valid and hold until every expected word has come back.
    task drain();
        @(negedge clk);
        req_valid <= 1'b0;
        burst_left = 0;
        while (model.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_reg(input logic [CFGI_W-1:0] idx, input logic [KEY_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        model.write_reg(idx, data);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task set_range(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi);
        drain();
        write_reg(REG_RANGE_LOW, lo);
        write_reg(REG_RANGE_HIGH, hi);
    endtask

    // Keys: mostly near the range floor or already held, so adds, removes
    // and cursor chains hit real entries; some noise and edge values.
    function logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] span;
        int               r;
        span = model.top_key() - model.lo;
        r    = $urandom_range(0, 99);
        if (r < 45)
            return model.lo + $urandom_range(0, (span < 40) ? span : 40);
        if (r < 65)
            return (model.held > 0) ? model.keys[$urandom_range(0, model.held - 1)]
                                    : model.lo;
        if (r < 75)
            return model.cur_last;
        if (r < 85)
            return $urandom;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return NONE_VALUE;
            2: return model.lo;
            3: return model.top_key();
            4: return model.lo - 1;
            default: return model.top_key() + 1;
        endcase
    endfunction

    task random_item();
        int               r;
        logic [FUNC_W-1:0] f;
        logic [KEY_W-1:0]  k;
        r = $urandom_range(0, 99);
        if (r < 30)      f = FN_ADD;
        else if (r < 45) f = FN_REM;
        else if (r < 55) f = FN_CON;
        else if (r < 70) f = FN_NG;
        else if (r < 83) f = FN_NL;
        else if (r < 89) f = FN_FIRST;
        else if (r < 95) f = FN_LAST;
        else             f = 3'd7;
        k = pick_key();
        // follow the cursor chain most of the time
        if ((f == FN_NG || f == FN_NL) && $urandom_range(0, 9) < 6)
            k = model.cur_last;
        send(f, k);
    endtask

    initial
    begin
        logic [KEY_W-1:0] lo;
        logic [KEY_W-1:0] hi;
        int               phase;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty-set queries, range edges, duplicates, cursor walks
        send(FN_NG, 32'd0);
        send(FN_NL, 32'd0);
        send(FN_FIRST, 32'd0);
        send(FN_LAST, NONE_VALUE);
        send(FN_CON, 32'd0);
        send(FN_REM, 32'd5);
        send(FN_ADD, 32'd0);
        send(FN_ADD, RANGE_HI_RST);
        send(FN_ADD, NONE_VALUE);
        send(FN_ADD, 32'd0);
        send(FN_ADD, 32'd100);
        send(FN_ADD, 32'd50);
        send(FN_FIRST, 32'd0);
        send(FN_NG, 32'd0);
        send(FN_NG, 32'd50);
        send(FN_NG, 32'd100);
        send(FN_NG, RANGE_HI_RST);
        send(FN_LAST, 32'd0);
        send(FN_NL, RANGE_HI_RST);
        send(FN_NL, 32'd7);
        send(FN_NL, 32'd0);
        send(FN_NG, 32'd7);
        send(FN_CON, NONE_VALUE);
        send(FN_REM, 32'd77);
        send(FN_REM, 32'd50);
        send(3'd7, NONE_VALUE);

        // Random phases: extreme range settings first, then random ones
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: begin lo = '0;         hi = NONE_VALUE; end
                1: begin lo = NONE_VALUE; hi = NONE_VALUE; end
                2: begin lo = '0;         hi = '0;         end
                3: begin lo = 32'd500;    hi = 32'd100;    end
                default:
                begin
                    lo = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 2000);
                    hi = ($urandom_range(0, 2) == 0) ? $urandom : lo + $urandom_range(0, 60);
                end
            endcase
            set_range(lo, hi);
            repeat (33) random_item();
        end

        drain();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
